>>> src/cost_priority_task_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler checker.
`ifndef COST_PRIORITY_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define COST_PRIORITY_TASK_SCHEDULER_UNIT_DEFINES_SVH

// Implication checked outside reset.
`define CPTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication that is also checked across reset.
`define CPTS_ASSERT_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

>>> src/cpts_pkg.sv
// Shared types and constants of the cost priority task scheduler.
`default_nettype none
package cpts_pkg;
  localparam int ID_W = 16;
  localparam int PRIO_W = 32;
  localparam int CPU_W = 4;
  localparam int DEF_NUM_CPUS = 16;
  localparam int DEF_QUEUE_DEPTH = 64;

  typedef enum logic [2:0] {
    OP_ADD_READY = 3'd0,
    OP_UNBLOCK = 3'd1,
    OP_GET_TASK = 3'd2,
    OP_REQ_POLL = 3'd3,
    OP_REL_POLL = 3'd4,
    OP_GET_IDLE = 3'd5,
    OP_DISABLE = 3'd6,
    OP_CPU_IDLE = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_NONE = 4'd0,
    ST_TO_REQ = 4'd1,
    ST_TO_POLLER = 4'd2,
    ST_QUEUED_WAKE = 4'd3,
    ST_QUEUED = 4'd4,
    ST_POLL_GRANT = 4'd5,
    ST_POLL_REFUSE = 4'd6,
    ST_IN_SUCC = 4'd7,
    ST_DROPPED = 4'd8,
    ST_RELEASED = 4'd9,
    ST_NOT_OWNER = 4'd10,
    ST_IDLE_CPU = 4'd11,
    ST_RSV12 = 4'd12,
    ST_RSV13 = 4'd13,
    ST_RSV14 = 4'd14,
    ST_RSV15 = 4'd15
  } status_t;

  typedef struct packed {
    op_t operation;
    logic [ID_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
    logic [CPU_W-1:0] cpu_id;
    logic has_cpu;
    logic child_hint;
    logic force_req;
  } req_t;

  typedef struct packed {
    status_t status;
    logic [ID_W-1:0] task_id_res;
    logic [CPU_W-1:0] cpu_id_res;
  } rsp_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0] id;
  } ent_t;

  // Command broadcast to every cell of a queue.
  typedef struct packed {
    logic push;
    logic pop;
    ent_t ent;
  } qcmd_t;

  // Queue state seen by the controller.
  typedef struct packed {
    logic full;
    logic empty;
    ent_t top;
  } qstat_t;
endpackage
`default_nettype wire

>>> src/cpts_cell.sv
// One cell of a sorted queue: holds one entry and trades with its neighbors.
`default_nettype none
module cpts_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cpts_pkg::qcmd_t cmd,
  input  wire logic          left_lt,
  input  wire logic          left_valid,
  input  wire cpts_pkg::ent_t left_ent,
  input  wire logic          right_valid,
  input  wire cpts_pkg::ent_t right_ent,
  output logic               valid,
  output cpts_pkg::ent_t     ent,
  output logic               lt
);
  logic valid_next;
  cpts_pkg::ent_t ent_next;

  // New entry goes after every entry of equal or higher cost
  assign lt = !valid || (ent.prio < cmd.ent.prio);

  // Shift left on pop, open a gap on push
  always_comb begin
    valid_next = valid;
    ent_next = ent;
    if (cmd.pop) begin
      valid_next = right_valid;
      ent_next = right_ent;
    end else if (cmd.push) begin
      if (left_lt) begin
        valid_next = left_valid;
        ent_next = left_ent;
      end else if (lt) begin
        valid_next = 1'b1;
        ent_next = cmd.ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    ent <= ent_next;
  end
endmodule
`default_nettype wire

>>> src/cpts_queue.sv
// Max-cost queue built as a row of sorted cells; the head is the best entry.
`default_nettype none
module cpts_queue #(
  parameter int DEPTH = cpts_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cpts_pkg::qcmd_t cmd,
  output cpts_pkg::qstat_t     stat
);
  logic v [DEPTH];
  logic l [DEPTH];
  cpts_pkg::ent_t e [DEPTH];

  // Chain the cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic lin_lt;
    logic lin_v;
    cpts_pkg::ent_t lin_e;
    logic rin_v;
    cpts_pkg::ent_t rin_e;

    if (i == 0) begin : g_head
      assign lin_lt = 1'b0;
      assign lin_v = 1'b0;
      assign lin_e = '0;
    end else begin : g_mid
      assign lin_lt = l[i-1];
      assign lin_v = v[i-1];
      assign lin_e = e[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rin_v = 1'b0;
      assign rin_e = '0;
    end else begin : g_body
      assign rin_v = v[i+1];
      assign rin_e = e[i+1];
    end

    cpts_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .left_lt(lin_lt), .left_valid(lin_v), .left_ent(lin_e),
      .right_valid(rin_v), .right_ent(rin_e),
      .valid(v[i]), .ent(e[i]), .lt(l[i])
    );
  end

  assign stat.full = v[DEPTH-1];
  assign stat.empty = !v[0];
  assign stat.top = e[0];
endmodule
`default_nettype wire

>>> src/cost_priority_task_scheduler_unit.sv
// A request word is accepted in S_IDLE and its result word is registered in S_EXEC; no
// new word is accepted until the state is back in S_IDLE. A get that takes the ready head
// while the successor slot is full adds an S_PUSH2 pass that puts the successor back into
// the ready row. Each queue row settles one insert or one removal per cycle; a stalled
// result word delays the next commit. Reset: synchronous; clears queues, successor valid
// bits, idle count and polling slot. Idle stack contents are not cleared.
`default_nettype none
module cost_priority_task_scheduler_unit #(
  parameter int NUM_CPUS = cpts_pkg::DEF_NUM_CPUS,
  parameter int QUEUE_DEPTH = cpts_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire cpts_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output cpts_pkg::rsp_t     rsp
);
  localparam int CIW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int ICW = $clog2(NUM_CPUS + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_PUSH2} state_t;
  typedef enum logic [1:0] {PK_NONE, PK_SUCC, PK_UNB, PK_RDY} pick_t;

  state_t state;
  cpts_pkg::req_t item;
  logic succ_v [NUM_CPUS];
  cpts_pkg::ent_t succ_e [NUM_CPUS];
  logic [cpts_pkg::CPU_W-1:0] idle_stk [NUM_CPUS];
  logic [ICW-1:0] idle_cnt;
  logic poll_held;
  logic [cpts_pkg::CPU_W-1:0] poll_cpu;

  cpts_pkg::qcmd_t rq_cmd, uq_cmd;
  cpts_pkg::qstat_t rq_st, uq_st;

  cpts_queue #(.DEPTH(QUEUE_DEPTH)) u_rdy (.clk(clk), .rst(rst), .cmd(rq_cmd), .stat(rq_st));
  cpts_queue #(.DEPTH(QUEUE_DEPTH)) u_unb (.clk(clk), .rst(rst), .cmd(uq_cmd), .stat(uq_st));

  logic [CIW+cpts_pkg::CPU_W-1:0] cpu_ext;
  logic [CIW-1:0] idx;
  logic cpu_ok;
  cpts_pkg::ent_t e_new, se;
  logic sv;
  logic [ICW-1:0] idle_dec;
  logic idle_full, idle_any;
  logic [cpts_pkg::CPU_W-1:0] idle_top;
  logic out_free, commit;

  assign cpu_ext = {{CIW{1'b0}}, item.cpu_id};
  assign idx = cpu_ext[CIW-1:0];
  assign cpu_ok = ({{(32-cpts_pkg::CPU_W){1'b0}}, item.cpu_id} < 32'(NUM_CPUS));
  assign e_new = {item.priority_req, item.task_id};
  assign sv = cpu_ok && succ_v[idx];
  assign se = succ_e[idx];
  assign idle_dec = idle_cnt - 1'b1;
  assign idle_full = (idle_cnt == ICW'(NUM_CPUS));
  assign idle_any = (idle_cnt != '0);
  assign idle_top = idle_stk[idle_dec[CIW-1:0]];
  assign out_free = !rsp_valid || rsp_ready;
  assign commit = (state == S_EXEC) && out_free;
  assign req_ready = (state == S_IDLE);

  // Pick the best source for a get
  pick_t pick;
  logic [cpts_pkg::PRIO_W-1:0] bp_s, bp_u;
  pick_t pick_su;
  always_comb begin
    pick_su = sv ? PK_SUCC : PK_NONE;
    bp_s = se.prio;
    if (!uq_st.empty && (!sv || (se.prio < uq_st.top.prio))) begin
      pick_su = PK_UNB;
      bp_s = uq_st.top.prio;
    end
    bp_u = bp_s;
    pick = pick_su;
    if (!rq_st.empty && ((pick_su == PK_NONE) || (bp_u < rq_st.top.prio))) begin
      pick = PK_RDY;
    end
  end

  // Decide the word's effects
  cpts_pkg::rsp_t rsp_n;
  logic succ_clr, succ_wr, do_push_idle, do_pop_idle, need_push2;
  logic poll_set, poll_clr;
  logic give;
  always_comb begin
    rsp_n = '0;
    rq_cmd = '0;
    uq_cmd = '0;
    succ_clr = 1'b0;
    succ_wr = 1'b0;
    do_push_idle = 1'b0;
    do_pop_idle = 1'b0;
    need_push2 = 1'b0;
    poll_set = 1'b0;
    poll_clr = 1'b0;
    give = 1'b0;
    rq_cmd.ent = e_new;
    uq_cmd.ent = e_new;

    // Take a task for the requester
    if ((item.operation == cpts_pkg::OP_GET_TASK || item.operation == cpts_pkg::OP_REQ_POLL)
        && cpu_ok && pick != PK_NONE) begin
      give = 1'b1;
      rsp_n.status = cpts_pkg::ST_TO_REQ;
      case (pick)
        PK_SUCC: begin
          rsp_n.task_id_res = se.id;
          succ_clr = 1'b1;
        end
        PK_UNB: begin
          rsp_n.task_id_res = uq_st.top.id;
          uq_cmd.pop = 1'b1;
          if (sv && !rq_st.full) begin
            rq_cmd.push = 1'b1;
            rq_cmd.ent = se;
            succ_clr = 1'b1;
          end
        end
        default: begin
          rsp_n.task_id_res = rq_st.top.id;
          rq_cmd.pop = 1'b1;
          if (sv) begin
            need_push2 = 1'b1;
            succ_clr = 1'b1;
          end
        end
      endcase
    end

    case (item.operation)
      cpts_pkg::OP_ADD_READY: begin
        if (item.has_cpu && cpu_ok && !item.child_hint && !succ_v[idx]) begin
          succ_wr = 1'b1;
          rsp_n.status = cpts_pkg::ST_IN_SUCC;
        end else if (poll_held) begin
          poll_clr = 1'b1;
          rsp_n.status = cpts_pkg::ST_TO_POLLER;
          rsp_n.task_id_res = item.task_id;
          rsp_n.cpu_id_res = poll_cpu;
        end else if (rq_st.full) begin
          rsp_n.status = cpts_pkg::ST_DROPPED;
        end else begin
          rq_cmd.push = 1'b1;
          if (idle_any) begin
            do_pop_idle = 1'b1;
            rsp_n.status = cpts_pkg::ST_QUEUED_WAKE;
            rsp_n.cpu_id_res = idle_top;
          end else begin
            rsp_n.status = cpts_pkg::ST_QUEUED;
          end
        end
      end
      cpts_pkg::OP_UNBLOCK: begin
        if (poll_held) begin
          poll_clr = 1'b1;
          rsp_n.status = cpts_pkg::ST_TO_POLLER;
          rsp_n.task_id_res = item.task_id;
          rsp_n.cpu_id_res = poll_cpu;
        end else if (uq_st.full) begin
          rsp_n.status = cpts_pkg::ST_DROPPED;
        end else begin
          uq_cmd.push = 1'b1;
          rsp_n.status = cpts_pkg::ST_QUEUED;
        end
      end
      cpts_pkg::OP_GET_TASK: begin
        if (cpu_ok && !give) begin
          do_push_idle = 1'b1;
        end
      end
      cpts_pkg::OP_REQ_POLL: begin
        if (cpu_ok && !give) begin
          if (!poll_held) begin
            poll_set = 1'b1;
            rsp_n.status = cpts_pkg::ST_POLL_GRANT;
            rsp_n.cpu_id_res = item.cpu_id;
          end else begin
            do_push_idle = 1'b1;
            rsp_n.status = cpts_pkg::ST_POLL_REFUSE;
          end
        end
      end
      cpts_pkg::OP_REL_POLL: begin
        if (cpu_ok) begin
          if (poll_held && poll_cpu == item.cpu_id) begin
            poll_clr = 1'b1;
            do_push_idle = 1'b1;
            rsp_n.status = cpts_pkg::ST_RELEASED;
          end else begin
            rsp_n.status = cpts_pkg::ST_NOT_OWNER;
          end
        end
      end
      cpts_pkg::OP_GET_IDLE: begin
        if ((item.force_req || !rq_st.empty || !uq_st.empty) && idle_any) begin
          do_pop_idle = 1'b1;
          rsp_n.status = cpts_pkg::ST_IDLE_CPU;
          rsp_n.cpu_id_res = idle_top;
        end
      end
      cpts_pkg::OP_DISABLE: begin
        if (sv) begin
          succ_clr = 1'b1;
          if (rq_st.full) begin
            rsp_n.status = cpts_pkg::ST_DROPPED;
          end else begin
            rq_cmd.push = 1'b1;
            rq_cmd.ent = se;
            rsp_n.status = cpts_pkg::ST_QUEUED;
          end
        end
      end
      default: begin
        if (cpu_ok) begin
          do_push_idle = 1'b1;
        end
      end
    endcase

    // Gate queue moves to the commit cycle; second pass requeues the successor
    if (state == S_PUSH2) begin
      rq_cmd.push = 1'b1;
      rq_cmd.pop = 1'b0;
      rq_cmd.ent = se;
      uq_cmd.push = 1'b0;
      uq_cmd.pop = 1'b0;
    end else if (!commit) begin
      rq_cmd.push = 1'b0;
      rq_cmd.pop = 1'b0;
      uq_cmd.push = 1'b0;
      uq_cmd.pop = 1'b0;
    end
  end

  // Sequencer, scheduler state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idle_cnt <= '0;
      poll_held <= 1'b0;
      poll_cpu <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        succ_v[i] <= 1'b0;
      end
    end else begin
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            rsp <= rsp_n;
            state <= need_push2 ? S_PUSH2 : S_IDLE;
            if (succ_clr) begin
              succ_v[idx] <= 1'b0;
            end
            if (succ_wr) begin
              succ_v[idx] <= 1'b1;
            end
            if (poll_clr) begin
              poll_held <= 1'b0;
            end
            if (poll_set) begin
              poll_held <= 1'b1;
              poll_cpu <= item.cpu_id;
            end
            if (do_pop_idle) begin
              idle_cnt <= idle_dec;
            end
            if (do_push_idle && !idle_full) begin
              idle_cnt <= idle_cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (commit) begin
      if (succ_wr) begin
        succ_e[idx] <= e_new;
      end
      if (do_push_idle && !idle_full) begin
        idle_stk[idle_cnt[CIW-1:0]] <= item.cpu_id;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/cpts_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none
`include "cost_priority_task_scheduler_unit_defines.svh"
module cpts_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire cpts_pkg::rsp_t rsp
);
  logic tid_st, cpu_st;
  assign tid_st = (rsp.status == cpts_pkg::ST_TO_REQ) || (rsp.status == cpts_pkg::ST_TO_POLLER);
  assign cpu_st = (rsp.status == cpts_pkg::ST_TO_POLLER) ||
                  (rsp.status == cpts_pkg::ST_QUEUED_WAKE) ||
                  (rsp.status == cpts_pkg::ST_POLL_GRANT) ||
                  (rsp.status == cpts_pkg::ST_IDLE_CPU);

  // Hold a stalled result word
  `CPTS_ASSERT_IMP(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(rsp)))
  // Take one request word at a time
  `CPTS_ASSERT_IMP(a_req_one, clk, rst, req_valid && req_ready, ##1 !req_ready)
  // Task field only carries a handed-out task
  `CPTS_ASSERT_IMP(a_tid_zero, clk, rst, rsp_valid && !tid_st, rsp.task_id_res == '0)
  // CPU field only carries a woken, polling or idle CPU
  `CPTS_ASSERT_IMP(a_cpu_zero, clk, rst, rsp_valid && !cpu_st, rsp.cpu_id_res == '0)
  // No result word right after reset
  `CPTS_ASSERT_NXT(a_rst_quiet, clk, rst, !rsp_valid)
endmodule

bind cost_priority_task_scheduler_unit cpts_checker u_cpts_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
`default_nettype wire

>>> bench/cost_priority_task_scheduler_unit_test.sv
// Self-checking bench for the cost priority task scheduler: predicts each result word.
`default_nettype none
module cost_priority_task_scheduler_unit_test;

  localparam int NCPU = 16;
  localparam int QDEPTH = 64;
  localparam int STALL_LIMIT = 20000;

  // Scoreboard: keeps its own copy of the scheduler state and the pending results.
  class sched_scoreboard;
    cpts_pkg::ent_t ready_q[$];
    cpts_pkg::ent_t unblk_q[$];
    bit succ_v[NCPU];
    cpts_pkg::ent_t succ_e[NCPU];
    logic [3:0] idle_stk[$];
    bit poll_held;
    logic [3:0] poll_cpu;
    cpts_pkg::rsp_t pending[$];
    int errors;
    int checked;

    function int top_index(ref cpts_pkg::ent_t q[$]);
      int best;
      best = 0;
      for (int i = 1; i < q.size(); i++)
        if (q[i].prio > q[best].prio) best = i;
      return best;
    endfunction

    function void push_idle(logic [3:0] cpu);
      if (idle_stk.size() < NCPU) idle_stk.push_back(cpu);
    endfunction

    // Take the best task for a CPU; return 0 when nothing is available.
    function bit pick(logic [3:0] cpu, output logic [cpts_pkg::ID_W-1:0] id);
      int src;
      int ui;
      int ri;
      logic [cpts_pkg::PRIO_W-1:0] bp;
      src = 0;
      bp = '0;
      ui = 0;
      ri = 0;
      if (succ_v[cpu]) begin
        src = 1;
        bp = succ_e[cpu].prio;
      end
      if (unblk_q.size() > 0) begin
        ui = top_index(unblk_q);
        if (src == 0 || bp < unblk_q[ui].prio) begin
          src = 2;
          bp = unblk_q[ui].prio;
        end
      end
      if (ready_q.size() > 0) begin
        ri = top_index(ready_q);
        if (src == 0 || bp < ready_q[ri].prio) begin
          src = 3;
          bp = ready_q[ri].prio;
        end
      end
      id = '0;
      if (src == 0) return 0;
      if (src == 1) begin
        id = succ_e[cpu].id;
        succ_v[cpu] = 0;
        return 1;
      end
      if (src == 3) begin
        id = ready_q[ri].id;
        ready_q.delete(ri);
      end else begin
        id = unblk_q[ui].id;
        unblk_q.delete(ui);
      end
      // Move the losing successor into the ready queue when there is room.
      if (succ_v[cpu] && ready_q.size() < QDEPTH) begin
        ready_q.push_back(succ_e[cpu]);
        succ_v[cpu] = 0;
      end
      return 1;
    endfunction

    function void note_request(cpts_pkg::req_t r);
      cpts_pkg::rsp_t x;
      cpts_pkg::ent_t e;
      logic [cpts_pkg::ID_W-1:0] tid;
      x = '{status: cpts_pkg::ST_NONE, task_id_res: '0, cpu_id_res: '0};
      e.id = r.task_id;
      e.prio = r.priority_req;
      case (r.operation)
        cpts_pkg::OP_ADD_READY: begin
          if (r.has_cpu && !r.child_hint && !succ_v[r.cpu_id]) begin
            succ_e[r.cpu_id] = e;
            succ_v[r.cpu_id] = 1;
            x.status = cpts_pkg::ST_IN_SUCC;
          end else if (poll_held) begin
            poll_held = 0;
            x.status = cpts_pkg::ST_TO_POLLER;
            x.task_id_res = e.id;
            x.cpu_id_res = poll_cpu;
          end else if (ready_q.size() >= QDEPTH) begin
            x.status = cpts_pkg::ST_DROPPED;
          end else begin
            ready_q.push_back(e);
            if (idle_stk.size() > 0) begin
              x.status = cpts_pkg::ST_QUEUED_WAKE;
              x.cpu_id_res = idle_stk.pop_back();
            end else begin
              x.status = cpts_pkg::ST_QUEUED;
            end
          end
        end
        cpts_pkg::OP_UNBLOCK: begin
          if (poll_held) begin
            poll_held = 0;
            x.status = cpts_pkg::ST_TO_POLLER;
            x.task_id_res = e.id;
            x.cpu_id_res = poll_cpu;
          end else if (unblk_q.size() >= QDEPTH) begin
            x.status = cpts_pkg::ST_DROPPED;
          end else begin
            unblk_q.push_back(e);
            x.status = cpts_pkg::ST_QUEUED;
          end
        end
        cpts_pkg::OP_GET_TASK: begin
          if (pick(r.cpu_id, tid)) begin
            x.status = cpts_pkg::ST_TO_REQ;
            x.task_id_res = tid;
          end else begin
            push_idle(r.cpu_id);
          end
        end
        cpts_pkg::OP_REQ_POLL: begin
          if (pick(r.cpu_id, tid)) begin
            x.status = cpts_pkg::ST_TO_REQ;
            x.task_id_res = tid;
          end else if (!poll_held) begin
            poll_held = 1;
            poll_cpu = r.cpu_id;
            x.status = cpts_pkg::ST_POLL_GRANT;
            x.cpu_id_res = r.cpu_id;
          end else begin
            push_idle(r.cpu_id);
            x.status = cpts_pkg::ST_POLL_REFUSE;
          end
        end
        cpts_pkg::OP_REL_POLL: begin
          if (poll_held && poll_cpu == r.cpu_id) begin
            poll_held = 0;
            push_idle(r.cpu_id);
            x.status = cpts_pkg::ST_RELEASED;
          end else begin
            x.status = cpts_pkg::ST_NOT_OWNER;
          end
        end
        cpts_pkg::OP_GET_IDLE: begin
          if ((r.force_req || ready_q.size() > 0 || unblk_q.size() > 0) &&
              idle_stk.size() > 0) begin
            x.status = cpts_pkg::ST_IDLE_CPU;
            x.cpu_id_res = idle_stk.pop_back();
          end
        end
        cpts_pkg::OP_DISABLE: begin
          if (succ_v[r.cpu_id]) begin
            succ_v[r.cpu_id] = 0;
            if (ready_q.size() < QDEPTH) begin
              ready_q.push_back(succ_e[r.cpu_id]);
              x.status = cpts_pkg::ST_QUEUED;
            end else begin
              x.status = cpts_pkg::ST_DROPPED;
            end
          end
        end
        default: push_idle(r.cpu_id);
      endcase
      pending.push_back(x);
    endfunction

    function void check_result(cpts_pkg::rsp_t got);
      cpts_pkg::rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %p", got);
        return;
      end
      want = pending[0];
      pending.delete(0);
      checked++;
      if (got.status !== want.status || got.task_id_res !== want.task_id_res ||
          got.cpu_id_res !== want.cpu_id_res) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d task %0h cpu %0d, got %0d %0h %0d",
                   want.status, want.task_id_res, want.cpu_id_res,
                   got.status, got.task_id_res, got.cpu_id_res);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  cpts_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  cpts_pkg::rsp_t rsp;

  sched_scoreboard board;
  int idle_cycles = 0;
  int words_sent = 0;

  cost_priority_task_scheduler_unit i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  function int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Drain results with random stalls and check each accepted word.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) board.check_result(rsp);
      rsp_ready <= (gap_len() == 0) || ($urandom_range(3) == 0);
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Send one word and hold it until accepted, then add an optional gap.
  task send_word(cpts_pkg::req_t r, int gap);
    req <= r;
    req_valid <= 1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_request(r);
    words_sent++;
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function cpts_pkg::req_t make_word(cpts_pkg::op_t op, logic [cpts_pkg::ID_W-1:0] id,
                                     logic [cpts_pkg::PRIO_W-1:0] pr,
                                     logic [3:0] cpu, bit hc, bit ch, bit fr);
    cpts_pkg::req_t r;
    r.operation = op;
    r.task_id = id;
    r.priority_req = pr;
    r.cpu_id = cpu;
    r.has_cpu = hc;
    r.child_hint = ch;
    r.force_req = fr;
    return r;
  endfunction

  function cpts_pkg::req_t random_word();
    cpts_pkg::req_t r;
    int p;
    r = cpts_pkg::req_t'(($bits(cpts_pkg::req_t))'({$urandom, $urandom}));
    p = $urandom_range(99);
    // Favor adds and gets so the queues fill and drain.
    if (p < 30) r.operation = cpts_pkg::OP_ADD_READY;
    else if (p < 45) r.operation = cpts_pkg::OP_UNBLOCK;
    else if (p < 70) r.operation = cpts_pkg::OP_GET_TASK;
    else r.operation = cpts_pkg::op_t'($urandom_range(7, 3));
    if ($urandom_range(3) != 0) r.priority_req = $urandom_range(15);
    return r;
  endfunction

  task wait_drained();
    req_valid <= 0;
    @(posedge clk);
    while (board.pending.size() > 0) @(posedge clk);
  endtask

  initial begin
    cpts_pkg::req_t r;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every operation, polling and idle corner cases.
    send_word(make_word(cpts_pkg::OP_GET_TASK, 0, 0, 4'd3, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_GET_IDLE, 0, 0, 0, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_GET_IDLE, 0, 0, 0, 0, 0, 1), 0);
    send_word(make_word(cpts_pkg::OP_CPU_IDLE, 0, 0, 4'd15, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_REL_POLL, 0, 0, 4'd2, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_REQ_POLL, 0, 0, 4'd2, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_REQ_POLL, 0, 0, 4'd2, 0, 0, 0), 1);
    send_word(make_word(cpts_pkg::OP_REL_POLL, 0, 0, 4'd5, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_REL_POLL, 0, 0, 4'd2, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_REQ_POLL, 0, 0, 4'd7, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_UNBLOCK, 16'hffff, '1, 0, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_ADD_READY, 16'h1234, 32'd5, 4'd1, 1, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_ADD_READY, 16'h0, 32'd5, 4'd1, 1, 0, 0), 2);
    send_word(make_word(cpts_pkg::OP_ADD_READY, 16'h00aa, 32'hffffffff, 4'd0, 1, 1, 0), 0);
    send_word(make_word(cpts_pkg::OP_UNBLOCK, 16'h00bb, 32'd5, 0, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_GET_TASK, 0, 0, 4'd1, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_GET_TASK, 0, 0, 4'd1, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_ADD_READY, 16'h0c0c, 32'd0, 4'd4, 1, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_DISABLE, 0, 0, 4'd4, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_DISABLE, 0, 0, 4'd4, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_GET_IDLE, 0, 0, 0, 0, 0, 0), 0);
    for (int i = 0; i < 18; i++)
      send_word(make_word(cpts_pkg::OP_CPU_IDLE, 0, 0, i[3:0], 0, 0, 0), 0);
    // Fill the ready queue past full, then drain it.
    for (int i = 0; i < QDEPTH + 3; i++)
      send_word(make_word(cpts_pkg::OP_ADD_READY, i[15:0], i % 7, 0, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_ADD_READY, 16'h5555, 32'd9, 4'd6, 1, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_UNBLOCK, 16'h6666, 32'd99, 0, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_GET_TASK, 0, 0, 4'd6, 0, 0, 0), 0);
    send_word(make_word(cpts_pkg::OP_DISABLE, 0, 0, 4'd6, 0, 0, 0), 0);
    for (int i = 0; i < QDEPTH + 3; i++)
      send_word(make_word(cpts_pkg::OP_UNBLOCK, i[15:0], i % 5, 0, 0, 0, 0), 0);
    for (int i = 0; i < 2 * QDEPTH + 4; i++)
      send_word(make_word(cpts_pkg::OP_GET_TASK, 0, 0, i[3:0], 0, 0, 0), 0);

    // Let everything settle once before the random part.
    wait_drained();

    // Random traffic with gaps.
    for (int i = 0; i < 1400; i++) begin
      r = random_word();
      send_word(r, gap_len());
      if (i == 700) wait_drained();
    end
    req_valid <= 0;

    while (board.pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d request words, checked %0d results; queues reached full and empty.",
             words_sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
